[rtl/mdes_pkg.sv]
package mdes_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_BEND,
    ST_ENQ,
    ST_ENQ_RD,
    ST_ENQ_WR,
    ST_TICK_RD,
    ST_TICK,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_PREP,
    B_DIV
  } bend_state_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] value_main;
    logic [6:0]  value_extra;
    logic [1:0]  channel;
  } slot_t;

  localparam logic [1:0] OP_MIDI  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_ARM   = 2'd2;
  localparam logic [1:0] OP_SPLIT = 2'd3;

  localparam logic [1:0] CFG_MUTED  = 2'd0;
  localparam logic [1:0] CFG_ROTARY = 2'd1;
  localparam logic [1:0] CFG_BEND   = 2'd2;

  localparam logic [3:0] KIND_NOTEOFF  = 4'd0;
  localparam logic [3:0] KIND_NOTEON   = 4'd1;
  localparam logic [3:0] KIND_ALLOFF   = 4'd2;
  localparam logic [3:0] KIND_VOLUME   = 4'd3;
  localparam logic [3:0] KIND_PEDAL    = 4'd4;
  localparam logic [3:0] KIND_MOD      = 4'd5;
  localparam logic [3:0] KIND_DRAWBAR  = 4'd6;
  localparam logic [3:0] KIND_CHANVOL  = 4'd7;
  localparam logic [3:0] KIND_PROGRAM  = 4'd8;
  localparam logic [3:0] KIND_BEND     = 4'd9;
  localparam logic [3:0] KIND_SPLIT    = 4'd10;

  localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
  localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
  localparam logic [3:0] CMD_CONTROL  = 4'hB;
  localparam logic [3:0] CMD_PROGRAM  = 4'hC;
  localparam logic [3:0] CMD_BEND     = 4'hE;

  localparam logic [6:0] CC_MODWHEEL = 7'h01;
  localparam logic [6:0] CC_CHANVOL  = 7'h03;
  localparam logic [6:0] CC_VOLUME   = 7'h07;
  localparam logic [6:0] CC_PEDAL    = 7'h40;
  localparam logic [6:0] CC_DRAW_LO  = 7'h4B;
  localparam logic [6:0] CC_DRAW_HI  = 7'h53;
  localparam logic [6:0] CC_ALL_OFF  = 7'h78;

  localparam logic [6:0] PEDAL_THRESH = 7'd64;
  localparam logic [6:0] MOD_THRESH   = 7'd63;
  localparam logic [6:0] LEVEL_FULL   = 7'd127;

  localparam logic [1:0] CH_GLOBAL = 2'd3;
  localparam logic [1:0] CH_LOWER  = 2'd2;

  localparam logic [13:0] BEND_CENTER  = 14'd8192;
  localparam logic [13:0] BEND_UP_LIM  = 14'd8792;
  localparam logic [13:0] BEND_DN_LIM  = 14'd7592;
  localparam logic [15:0] RATIO_UNITY  = 16'd16384;
  localparam logic [3:0]  MAX_SEMIS    = 4'd12;

  // 2^(s/12) in Q16, minus one
  function automatic logic [16:0] bend_step(input logic [3:0] s);
    logic [16:0] r;
    unique case (s)
      4'd0:    r = 17'd0;
      4'd1:    r = 17'd3897;
      4'd2:    r = 17'd8026;
      4'd3:    r = 17'd12400;
      4'd4:    r = 17'd17034;
      4'd5:    r = 17'd21944;
      4'd6:    r = 17'd27146;
      4'd7:    r = 17'd32657;
      4'd8:    r = 17'd38496;
      4'd9:    r = 17'd44682;
      4'd10:   r = 17'd51236;
      4'd11:   r = 17'd58179;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

[rtl/midi_event_decode_and_schedule_top.sv]
// channel  | handshake           | payload
// in       | in_valid/in_ready   | opcode, status_byte, data_one, data_two, frame_offset
// out      | out_valid/out_ready | event_kind, value_main, value_extra, part_channel
// cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data
// An item is finished before the next is accepted; a downward pitch bend also waits on the
// bend unit's one-bit-per-cycle divider (15 steps after a multiply and a prep step).
// A tick or enqueue costs one registered read of the ring memory.
// Reset is synchronous; the ring needs no clearing pass.
// A result waiting on out_ready holds the sequencer before emit only.
module midi_event_decode_and_schedule_top import mdes_pkg::*; #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        opcode,
  input  logic [7:0]        status_byte,
  input  logic [6:0]        data_one,
  input  logic [6:0]        data_two,
  input  logic [15:0]       frame_offset,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        event_kind,
  output logic [15:0]       value_main,
  output logic [6:0]        value_extra,
  output logic signed [2:0] part_channel,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [3:0]        cfg_data
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  state_t state, state_next;

  logic       muted;
  logic       pedal_drives_rotary;
  logic [3:0] bend_semitones;

  logic [1:0]  op_q;
  logic [7:0]  st_q;
  logic [6:0]  d1_q;
  logic [6:0]  d2_q;
  logic [15:0] fr_q;

  logic [IDX_W-1:0] write_index;
  logic [IDX_W-1:0] read_index;
  logic [6:0]       split_note;
  logic             split_learn_armed;
  logic             queue_active;

  slot_t ev;
  slot_t res;

  logic [15:0] delay_mem [QUEUE_DEPTH];
  slot_t       slot_mem  [QUEUE_DEPTH];
  logic [15:0] delay_rd;
  slot_t       slot_rd;
  logic [IDX_W-1:0] rd_addr;
  logic             dly_we;
  logic [IDX_W-1:0] dly_waddr;
  logic [15:0]      dly_wdata;
  logic             slot_we;

  logic        bend_start;
  logic        bend_done;
  logic [15:0] bend_ratio;

  logic        dec_enq;
  logic        dec_learn;
  logic        dec_bend;
  slot_t       dec;
  logic [3:0]  cmd;
  logic [1:0]  chn;
  logic [6:0]  vel;
  logic        ring_full;
  logic        ring_empty;
  logic        emit_fire;
  logic [15:0] abs_diff;

  assign cfg_ready  = 1'b1;
  assign in_ready   = (state == ST_IDLE);
  assign ring_full  = (ring_inc(write_index) == read_index);
  assign ring_empty = (write_index == read_index);
  assign emit_fire  = (state == ST_EMIT) && (!out_valid || out_ready);
  assign abs_diff   = (fr_q < delay_rd) ? delay_rd - fr_q : fr_q - delay_rd;

  always_comb begin
    cmd       = st_q[7:4];
    chn       = (st_q[3:0] > 4'd2) ? 2'd0 : st_q[1:0];
    vel       = (cmd == CMD_NOTE_OFF) ? 7'd0 : d2_q;
    dec_enq   = 1'b0;
    dec_learn = 1'b0;
    dec_bend  = 1'b0;
    dec       = '{kind: KIND_NOTEOFF, value_main: 16'd0, value_extra: 7'd0,
                  channel: CH_GLOBAL};
    if (op_q == OP_MIDI && !muted) begin
      priority if (cmd == CMD_NOTE_ON || cmd == CMD_NOTE_OFF) begin
        if (vel != 7'd0 && split_learn_armed && d1_q != 7'd0) begin
          dec_learn = 1'b1;
          dec       = '{kind: KIND_SPLIT, value_main: 16'(d1_q), value_extra: 7'd0,
                        channel: CH_GLOBAL};
        end else begin
          dec_enq = 1'b1;
          dec     = '{kind: (vel == 7'd0) ? KIND_NOTEOFF : KIND_NOTEON,
                      value_main: 16'(d1_q), value_extra: vel,
                      channel: (split_note != 7'd0 && chn == 2'd0 && d1_q <= split_note)
                               ? CH_LOWER : chn};
        end
      end else if (cmd == CMD_CONTROL) begin
        priority if (d1_q >= CC_ALL_OFF) begin
          dec_enq  = 1'b1;
          dec.kind = KIND_ALLOFF;
        end else if (d1_q == CC_VOLUME) begin
          dec_enq        = 1'b1;
          dec.kind       = KIND_VOLUME;
          dec.value_main = 16'(d2_q);
        end else if (d1_q == CC_PEDAL) begin
          dec_enq        = 1'b1;
          dec.value_main = (d2_q > PEDAL_THRESH) ? 16'(LEVEL_FULL) : 16'd0;
          if (pedal_drives_rotary) begin
            dec.kind = KIND_MOD;
          end else begin
            dec.kind    = KIND_PEDAL;
            dec.channel = chn;
          end
        end else if (d1_q >= CC_DRAW_LO && d1_q <= CC_DRAW_HI) begin
          dec_enq         = 1'b1;
          dec.kind        = KIND_DRAWBAR;
          dec.value_main  = 16'(d1_q - CC_DRAW_LO);
          dec.value_extra = d2_q;
          dec.channel     = chn;
        end else if (d1_q == CC_CHANVOL) begin
          dec_enq        = 1'b1;
          dec.kind       = KIND_CHANVOL;
          dec.value_main = 16'(d2_q);
          dec.channel    = chn;
        end else if (d1_q == CC_MODWHEEL) begin
          dec_enq        = 1'b1;
          dec.kind       = KIND_MOD;
          dec.value_main = (d2_q < MOD_THRESH) ? 16'd0 : 16'd1;
        end else begin
          dec_enq = 1'b0;
        end
      end else if (cmd == CMD_PROGRAM) begin
        dec_enq        = 1'b1;
        dec.kind       = KIND_PROGRAM;
        dec.value_main = 16'(d1_q);
      end else if (cmd == CMD_BEND) begin
        dec_enq     = 1'b1;
        dec_bend    = 1'b1;
        dec.kind    = KIND_BEND;
        dec.channel = chn;
      end else begin
        dec_enq = 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    bend_start = 1'b0;
    rd_addr    = read_index;
    dly_we     = 1'b0;
    dly_waddr  = write_index;
    dly_wdata  = fr_q;
    slot_we    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        priority if (op_q == OP_TICK) begin
          state_next = (queue_active && !ring_empty) ? ST_TICK_RD : ST_IDLE;
        end else if (dec_learn) begin
          state_next = ST_EMIT;
        end else if (dec_bend) begin
          bend_start = 1'b1;
          state_next = ST_BEND;
        end else if (dec_enq) begin
          state_next = ST_ENQ;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_BEND: begin
        if (bend_done) begin
          state_next = ST_ENQ;
        end
      end
      ST_ENQ: begin
        state_next = ring_full ? ST_IDLE : ST_ENQ_RD;
      end
      ST_ENQ_RD: begin
        rd_addr    = ring_dec(write_index);
        state_next = ST_ENQ_WR;
      end
      ST_ENQ_WR: begin
        dly_we     = 1'b1;
        slot_we    = 1'b1;
        dly_wdata  = ring_empty ? fr_q : abs_diff;
        state_next = ST_IDLE;
      end
      ST_TICK_RD: begin
        state_next = ST_TICK;
      end
      ST_TICK: begin
        if (delay_rd == 16'd0) begin
          state_next = ST_EMIT;
        end else begin
          dly_we     = 1'b1;
          dly_waddr  = read_index;
          dly_wdata  = delay_rd - 16'd1;
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      muted               <= 1'b0;
      pedal_drives_rotary <= 1'b0;
      bend_semitones      <= 4'd2;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_MUTED) begin
        muted <= cfg_data[0];
      end else if (cfg_index == CFG_ROTARY) begin
        pedal_drives_rotary <= cfg_data[0];
      end else if (cfg_index == CFG_BEND) begin
        bend_semitones <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q <= opcode;
      st_q <= status_byte;
      d1_q <= data_one;
      d2_q <= data_two;
      fr_q <= frame_offset;
    end
    if (state == ST_DECODE) begin
      ev  <= dec;
      res <= dec;
    end
    if (state == ST_BEND && bend_done) begin
      ev.value_main <= bend_ratio;
    end
    if (state == ST_TICK) begin
      res <= slot_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index       <= '0;
      read_index        <= '0;
      split_note        <= '0;
      split_learn_armed <= 1'b0;
      queue_active      <= 1'b0;
    end else begin
      if (state == ST_DECODE) begin
        if (op_q == OP_ARM) begin
          split_learn_armed <= 1'b1;
        end
        if (op_q == OP_SPLIT || dec_learn) begin
          split_note <= d1_q;
        end
        if (dec_learn) begin
          split_learn_armed <= 1'b0;
        end
        if (op_q == OP_TICK && queue_active && ring_empty) begin
          queue_active <= 1'b0;
        end
      end
      if (state == ST_ENQ) begin
        queue_active <= 1'b1;
      end
      if (state == ST_ENQ_WR) begin
        write_index <= ring_inc(write_index);
      end
      if (state == ST_TICK && delay_rd == 16'd0) begin
        read_index <= ring_inc(read_index);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dly_we) begin
      delay_mem[dly_waddr] <= dly_wdata;
    end
    delay_rd <= delay_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[write_index] <= ev;
    end
    slot_rd <= slot_mem[read_index];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      event_kind   <= res.kind;
      value_main   <= res.value_main;
      value_extra  <= res.value_extra;
      part_channel <= (res.channel == CH_GLOBAL) ? -3'sd1 : $signed({1'b0, res.channel});
    end
  end

  mdes_bend_unit u_bend (
    .clk        (clk),
    .rst        (rst),
    .start      (bend_start),
    .bend_value ({d2_q, d1_q}),
    .semitones  (bend_semitones),
    .done       (bend_done),
    .ratio      (bend_ratio)
  );

`ifndef ASSERT_OFF
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (state == ST_IDLE) && !out_valid)
    else $error("not idle after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accepting a word");

  a_split_global: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == KIND_SPLIT |-> part_channel == -3'sd1)
    else $error("split learned word not global");

  a_bend_done_owner: assert property (@(posedge clk) disable iff (rst)
    bend_done |-> state == ST_BEND)
    else $error("bend result outside bend wait");
`endif

endmodule

[rtl/mdes_bend_unit.sv]
module mdes_bend_unit import mdes_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [13:0] bend_value,
  input  logic [3:0]  semitones,
  output logic        done,
  output logic [15:0] ratio
);

  bend_state_t bstate;
  logic        dir_up;
  logic [13:0] mag;
  logic [16:0] step;
  logic [29:0] prod;
  logic [30:0] den;
  logic [30:0] rem;
  logic [14:0] nbits;
  logic [14:0] quo;
  logic [3:0]  count;

  logic [30:0] den_c;
  logic [31:0] rem_sh;
  logic        fits;
  logic [14:0] quo_next;
  logic [30:0] prod_full;
  logic [30:0] up_sum;

  always_comb begin
    prod_full = 31'(mag) * 31'(step);
    den_c     = 31'd536870912 + 31'(prod);
    rem_sh    = {rem, nbits[14]};
    fits      = rem_sh >= {1'b0, den};
    quo_next  = {quo[13:0], fits};
    up_sum    = 31'(prod) + 31'd16384;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate <= B_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (bstate)
        B_IDLE: begin
          if (start) begin
            step <= bend_step((semitones > MAX_SEMIS) ? MAX_SEMIS : semitones);
            if (bend_value > BEND_UP_LIM) begin
              dir_up <= 1'b1;
              mag    <= bend_value - BEND_CENTER;
              bstate <= B_MUL;
            end else if (bend_value < BEND_DN_LIM) begin
              dir_up <= 1'b0;
              mag    <= BEND_CENTER - bend_value;
              bstate <= B_MUL;
            end else begin
              ratio <= RATIO_UNITY;
              done  <= 1'b1;
            end
          end
        end
        B_MUL: begin
          prod   <= prod_full[29:0];
          bstate <= B_PREP;
        end
        B_PREP: begin
          if (dir_up) begin
            ratio  <= RATIO_UNITY + 16'(up_sum >> 15);
            done   <= 1'b1;
            bstate <= B_IDLE;
          end else begin
            den    <= den_c;
            rem    <= 31'd268435456 + 31'(den_c[30:16]);
            nbits  <= den_c[15:1];
            quo    <= '0;
            count  <= '0;
            bstate <= B_DIV;
          end
        end
        B_DIV: begin
          rem   <= fits ? 31'(rem_sh - {1'b0, den}) : rem_sh[30:0];
          nbits <= {nbits[13:0], 1'b0};
          quo   <= quo_next;
          count <= count + 4'd1;
          if (count == 4'd14) begin
            ratio  <= {1'b0, quo_next};
            done   <= 1'b1;
            bstate <= B_IDLE;
          end
        end
        default: bstate <= B_IDLE;
      endcase
    end
  end

endmodule
